@@ design/rcw_pkg.sv @@
// Shared constants, codes and word types of the Reno congestion window sender.
`default_nettype none
package rcw_pkg;

  localparam int unsigned SeqBits   = 16;
  localparam int unsigned WinBits   = 7;
  localparam int unsigned CntBits   = 13;
  localparam int unsigned MaxWindow = 64;

  // event kinds
  localparam logic [1:0] FuncStart   = 2'd0;
  localparam logic [1:0] FuncAck     = 2'd1;
  localparam logic [1:0] FuncTimeout = 2'd2;

  // congestion phases
  localparam logic [1:0] PhaseSlow  = 2'd0;
  localparam logic [1:0] PhaseAvoid = 2'd1;
  localparam logic [1:0] PhaseRecov = 2'd2;

  // config register indexes
  localparam logic CfgInitSsthresh = 1'b0;
  localparam logic CfgDupAckThr    = 1'b1;

  typedef logic [SeqBits-1:0] seq_t;
  typedef logic [WinBits-1:0] win_t;

  // one event's send run plus the status after the event
  typedef struct packed {
    seq_t       base;
    seq_t       sent_len;
    win_t       start_off;
    win_t       end_off;
    logic       no_send;
    win_t       window;
    win_t       threshold;
    logic [1:0] phase;
    logic       done;
  } job_t;

  typedef struct packed {
    logic       send_valid;
    seq_t       seq_no;
    logic       is_resend;
    logic       last;
    win_t       window;
    win_t       threshold;
    logic [1:0] phase;
    logic       done;
  } result_t;

endpackage
`default_nettype wire

@@ design/rcw_front.sv @@
// Front end: takes events, updates congestion state and describes the send run.
`default_nettype none
module rcw_front (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_valid_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [rcw_pkg::WinBits-1:0]     cfg_data_i,
  input  wire logic                            accept_i,
  input  wire logic [1:0]                      func_i,
  input  wire logic [rcw_pkg::CntBits-1:0]     packet_count_i,
  input  wire logic [rcw_pkg::SeqBits-1:0]     ack_no_i,
  output rcw_pkg::job_t                        job_o
);

  localparam int unsigned PadBits = rcw_pkg::SeqBits - rcw_pkg::WinBits;

  function automatic rcw_pkg::win_t sat_win(input logic [rcw_pkg::WinBits:0] w);
    rcw_pkg::win_t r;
    if (w > (rcw_pkg::WinBits+1)'(rcw_pkg::MaxWindow)) begin
      r = rcw_pkg::WinBits'(rcw_pkg::MaxWindow);
    end else if (w == '0) begin
      r = rcw_pkg::WinBits'(1);
    end else begin
      r = w[rcw_pkg::WinBits-1:0];
    end
    return r;
  endfunction

  logic [1:0]    phase_q, phase_d;
  rcw_pkg::win_t cwnd_q, cwnd_d;
  rcw_pkg::win_t ssth_q, ssth_d;
  rcw_pkg::win_t avoid_q, avoid_d;
  logic [1:0]    dup_q, dup_d;
  logic [1:0]    dupthr_q, dupthr_d;
  rcw_pkg::seq_t base_q, base_d;
  rcw_pkg::seq_t next_q, next_d;
  rcw_pkg::seq_t end_q, end_d;
  rcw_pkg::seq_t unsent_q, unsent_d;
  logic          active_q, active_d;

  logic          do_send, go_back;
  rcw_pkg::seq_t unsent_pre, sent_len, msg_len, start16;
  rcw_pkg::win_t lim, cwnd_inc, half, avoid_inc;
  logic [1:0]    dup_inc;
  logic          no_send;

  always_comb begin
    phase_d    = phase_q;
    cwnd_d     = cwnd_q;
    ssth_d     = ssth_q;
    avoid_d    = avoid_q;
    dup_d      = dup_q;
    dupthr_d   = dupthr_q;
    base_d     = base_q;
    next_d     = next_q;
    end_d      = end_q;
    unsent_pre = unsent_q;
    active_d   = active_q;
    do_send    = 1'b0;
    go_back    = 1'b0;
    cwnd_inc   = sat_win({1'b0, cwnd_q} + (rcw_pkg::WinBits+1)'(1));
    half       = cwnd_q >> 1;
    avoid_inc  = avoid_q + rcw_pkg::WinBits'(1);
    dup_inc    = (dup_q == 2'd3) ? 2'd3 : dup_q + 2'd1;

    if (accept_i) begin
      unique case (func_i)
        rcw_pkg::FuncStart: begin
          if (!active_q) begin
            dup_d      = '0;
            base_d     = next_q;
            unsent_pre = next_q;
            end_d      = next_q + rcw_pkg::SeqBits'(packet_count_i);
            next_d     = end_d;
            if (packet_count_i != '0) begin
              active_d = 1'b1;
              do_send  = 1'b1;
            end
          end
        end
        rcw_pkg::FuncAck: begin
          if (active_q) begin
            if (ack_no_i == base_q) begin
              dup_d  = '0;
              base_d = base_q + rcw_pkg::SeqBits'(1);
              unique case (phase_q)
                rcw_pkg::PhaseSlow: begin
                  cwnd_d  = cwnd_inc;
                  do_send = 1'b1;
                  if (cwnd_inc >= ssth_q) phase_d = rcw_pkg::PhaseAvoid;
                end
                rcw_pkg::PhaseAvoid: begin
                  if (avoid_inc >= cwnd_q) begin
                    cwnd_d  = cwnd_inc;
                    avoid_d = '0;
                  end else begin
                    avoid_d = avoid_inc;
                  end
                  do_send = 1'b1;
                end
                default: begin
                  // leaving fast recovery: window falls back to the threshold
                  cwnd_d  = sat_win({1'b0, ssth_q});
                  phase_d = rcw_pkg::PhaseAvoid;
                end
              endcase
              active_d = (base_d != end_q);
            end else if (phase_q == rcw_pkg::PhaseRecov) begin
              cwnd_d  = cwnd_inc;
              do_send = 1'b1;
            end else begin
              dup_d = dup_inc;
              if (dup_inc == dupthr_q) begin
                ssth_d  = half;
                cwnd_d  = sat_win({1'b0, half} + (rcw_pkg::WinBits+1)'(3));
                go_back = 1'b1;
                do_send = 1'b1;
                phase_d = rcw_pkg::PhaseRecov;
                dup_d   = '0;
                avoid_d = '0;
              end
            end
          end
        end
        rcw_pkg::FuncTimeout: begin
          if (active_q) begin
            ssth_d  = half;
            cwnd_d  = rcw_pkg::WinBits'(1);
            avoid_d = '0;
            dup_d   = '0;
            go_back = 1'b1;
            do_send = 1'b1;
            phase_d = rcw_pkg::PhaseSlow;
          end
        end
        default: ;
      endcase
    end

    // send run in window offsets from the new base
    sent_len = unsent_pre - base_d;
    msg_len  = end_d - base_d;
    lim      = (msg_len < rcw_pkg::SeqBits'(cwnd_d)) ? msg_len[rcw_pkg::WinBits-1:0] : cwnd_d;
    start16  = go_back ? '0 : sent_len;
    no_send  = !do_send || (start16 >= {{PadBits{1'b0}}, lim});
    unsent_d = unsent_pre;
    if (!no_send && ({{PadBits{1'b0}}, lim} > sent_len)) begin
      unsent_d = base_d + rcw_pkg::SeqBits'(lim);
    end

    if (cfg_valid_i) begin
      if (cfg_index_i == rcw_pkg::CfgInitSsthresh) begin
        ssth_d = (cfg_data_i > rcw_pkg::WinBits'(rcw_pkg::MaxWindow)) ?
                 rcw_pkg::WinBits'(rcw_pkg::MaxWindow) : cfg_data_i;
      end else begin
        dupthr_d = cfg_data_i[1:0];
      end
    end
  end

  always_comb begin
    job_o.base      = base_d;
    job_o.sent_len  = sent_len;
    job_o.start_off = start16[rcw_pkg::WinBits-1:0];
    job_o.end_off   = lim;
    job_o.no_send   = no_send;
    job_o.window    = cwnd_d;
    job_o.threshold = ssth_d;
    job_o.phase     = phase_d;
    job_o.done      = !active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= rcw_pkg::PhaseSlow;
      cwnd_q   <= rcw_pkg::WinBits'(1);
      ssth_q   <= rcw_pkg::WinBits'(rcw_pkg::MaxWindow);
      avoid_q  <= '0;
      dup_q    <= '0;
      dupthr_q <= 2'd3;
      base_q   <= rcw_pkg::SeqBits'(1);
      next_q   <= rcw_pkg::SeqBits'(1);
      end_q    <= rcw_pkg::SeqBits'(1);
      unsent_q <= rcw_pkg::SeqBits'(1);
      active_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cwnd_q   <= cwnd_d;
      ssth_q   <= ssth_d;
      avoid_q  <= avoid_d;
      dup_q    <= dup_d;
      dupthr_q <= dupthr_d;
      base_q   <= base_d;
      next_q   <= next_d;
      end_q    <= end_d;
      unsent_q <= unsent_d;
      active_q <= active_d;
    end
  end

endmodule
`default_nettype wire

@@ design/rcw_jobq.sv @@
// Two-entry queue of send-run descriptors between front and back end.
`default_nettype none
module rcw_jobq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire rcw_pkg::job_t data_i,
  input  wire logic          pop_i,
  output rcw_pkg::job_t      data_o,
  output logic               full_o,
  output logic               empty_o
);

  rcw_pkg::job_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule
`default_nettype wire

@@ design/rcw_back.sv @@
// Back end: walks one send run and puts out one result word per cycle while its waiting word is popped.
`default_nettype none
module rcw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          job_vld_i,
  input  wire rcw_pkg::job_t job_i,
  output logic               job_pop_o,
  input  wire logic          res_pop_i,
  output logic               res_vld_o,
  output rcw_pkg::result_t   res_o
);

  localparam int unsigned PadBits = rcw_pkg::SeqBits - rcw_pkg::WinBits;

  logic              busy_q, res_vld_q;
  rcw_pkg::job_t     cur_q;
  rcw_pkg::win_t     off_q, off_nxt;
  rcw_pkg::result_t  res_q, res_d;
  logic              slot_free, emit;

  assign slot_free = !res_vld_q || res_pop_i;
  assign emit      = busy_q && slot_free;
  assign job_pop_o = !busy_q && job_vld_i;
  assign off_nxt   = off_q + rcw_pkg::WinBits'(1);

  always_comb begin
    res_d.window    = cur_q.window;
    res_d.threshold = cur_q.threshold;
    res_d.phase     = cur_q.phase;
    res_d.done      = cur_q.done;
    if (cur_q.no_send) begin
      res_d.send_valid = 1'b0;
      res_d.seq_no     = '0;
      res_d.is_resend  = 1'b0;
      res_d.last       = 1'b1;
    end else begin
      res_d.send_valid = 1'b1;
      res_d.seq_no     = cur_q.base + rcw_pkg::SeqBits'(off_q);
      res_d.is_resend  = ({{PadBits{1'b0}}, off_q} < cur_q.sent_len);
      res_d.last       = (off_nxt == cur_q.end_off);
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      cur_q <= job_i;
      off_q <= job_i.start_off;
    end else if (emit) begin
      off_q <= off_nxt;
    end
    if (emit) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (job_pop_o) begin
        busy_q <= 1'b1;
      end else if (emit && res_d.last) begin
        busy_q <= 1'b0;
      end
      if (emit) begin
        res_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule
`default_nettype wire

@@ design/reno_congestion_window_sender_unit.sv @@
// Top level of the Reno congestion window sender with Go-Back-N resend.
// An event word (start, ack, timeout) is taken whenever the two-entry
// job queue has room; the front end updates the congestion state right
// away. The back end then loads the job and puts out max(1, n) result
// words for that event, one per cycle while each waiting word is popped,
// where n is the number of send orders (at most the window, 64). The
// sustained event rate is thus set by the back end's single result port,
// and it drops whenever a waiting word is not popped.
// Config writes are always taken (ready is tied high).
`default_nettype none
module reno_congestion_window_sender_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [rcw_pkg::WinBits-1:0]   cfg_data_i,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    func_i,
  input  wire logic [rcw_pkg::CntBits-1:0]   packet_count_i,
  input  wire logic [rcw_pkg::SeqBits-1:0]   ack_no_i,
  output logic                               empty,
  input  wire logic                          pop,
  output logic                               send_valid_o,
  output logic [rcw_pkg::SeqBits-1:0]        seq_no_o,
  output logic                               is_resend_o,
  output logic                               last_o,
  output logic [rcw_pkg::WinBits-1:0]        window_o,
  output logic [rcw_pkg::WinBits-1:0]        threshold_o,
  output logic [1:0]                         phase_o,
  output logic                               done_res_o
);

  rcw_pkg::job_t    job_in, job_out;
  rcw_pkg::result_t res;
  logic             accept, jq_full, jq_empty, jq_pop, res_vld;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !jq_full;
  assign full        = jq_full;

  rcw_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .func_i         (func_i),
    .packet_count_i (packet_count_i),
    .ack_no_i       (ack_no_i),
    .job_o          (job_in)
  );

  rcw_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (job_in),
    .pop_i   (jq_pop),
    .data_o  (job_out),
    .full_o  (jq_full),
    .empty_o (jq_empty)
  );

  rcw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .job_vld_i (!jq_empty),
    .job_i     (job_out),
    .job_pop_o (jq_pop),
    .res_pop_i (pop),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  assign empty        = !res_vld;
  assign send_valid_o = res.send_valid;
  assign seq_no_o     = res.seq_no;
  assign is_resend_o  = res.is_resend;
  assign last_o       = res.last;
  assign window_o     = res.window;
  assign threshold_o  = res.threshold;
  assign phase_o      = res.phase;
  assign done_res_o   = res.done;

  // a status-only word always closes its event
  a_nosend_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !send_valid_o) |-> (last_o && seq_no_o == '0 && !is_resend_o))
    else $error("status-only word malformed");

  a_window_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (window_o != '0 &&
                window_o <= rcw_pkg::WinBits'(rcw_pkg::MaxWindow)))
    else $error("window out of range");

  a_thresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (threshold_o <= rcw_pkg::WinBits'(rcw_pkg::MaxWindow)))
    else $error("threshold out of range");

  a_word_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(seq_no_o) && $stable(last_o)))
    else $error("waiting word changed");

endmodule
`default_nettype wire

@@ sim/reno_congestion_window_sender_unit_tb.sv @@
// Self-checking testbench for the Reno congestion window sender: directed, random and full-rate runs.
`default_nettype none
module reno_congestion_window_sender_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rcw_pkg::*;

  localparam int unsigned SeqMask    = (32'd1 << SeqBits) - 1;
  localparam int unsigned MaxSends   = 64;
  localparam int unsigned DupSat     = 3;
  localparam int unsigned RecovBoost = 3;
  localparam logic [1:0]  FuncUnused = 2'd3;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i    = 1'b0;
  logic [WinBits-1:0] cfg_data_i     = '0;
  logic               push           = 1'b0;
  logic               full;
  logic [1:0]         func_i         = FuncStart;
  logic [CntBits-1:0] packet_count_i = '0;
  seq_t               ack_no_i       = '0;
  logic               empty;
  logic               pop            = 1'b0;
  logic               send_valid_o;
  seq_t               seq_no_o;
  logic               is_resend_o;
  logic               last_o;
  win_t               window_o;
  win_t               threshold_o;
  logic [1:0]         phase_o;
  logic               done_res_o;

  reno_congestion_window_sender_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .packet_count_i (packet_count_i),
    .ack_no_i       (ack_no_i),
    .empty          (empty),
    .pop            (pop),
    .send_valid_o   (send_valid_o),
    .seq_no_o       (seq_no_o),
    .is_resend_o    (is_resend_o),
    .last_o         (last_o),
    .window_o       (window_o),
    .threshold_o    (threshold_o),
    .phase_o        (phase_o),
    .done_res_o     (done_res_o)
  );

  always #10 clk_i = ~clk_i;

  // sender state mirror
  int unsigned m_phase, m_cwnd, m_ssth, m_avoid, m_dup, m_dup_thr;
  int unsigned m_base, m_next, m_end, m_unsent;
  bit          m_active;

  seq_t    run_seq[$];
  bit      run_resend[$];
  result_t exp_words[$];

  int err_count   = 0;
  int burst_left  = 0;
  bit tx_gap_en   = 1'b1;
  bit rx_stall_en = 1'b1;
  logic [9:0] rx_cyc = '0;

  function automatic int unsigned seq_dist(input int unsigned from_s, input int unsigned to_s);
    return (to_s - from_s) & SeqMask;
  endfunction

  function automatic int unsigned sat_win(input int unsigned w);
    if (w > MaxWindow) return MaxWindow;
    if (w < 1) return 1;
    return w;
  endfunction

  // queue up send orders from base_seq (go_back) or from the first unsent packet
  function automatic void emit_window(input bit go_back);
    int unsigned sent_len, msg_len, off;
    sent_len = seq_dist(m_base, m_unsent);
    msg_len  = seq_dist(m_base, m_end);
    off      = go_back ? 0 : sent_len;
    while (off < m_cwnd && off < msg_len && run_seq.size() < MaxSends) begin
      run_seq.push_back(seq_t'(m_base + off));
      run_resend.push_back(off < sent_len);
      off++;
    end
    if (off > sent_len && off <= msg_len) m_unsent = (m_base + off) & SeqMask;
  endfunction

  function automatic void predict_event(input logic [1:0] f, input logic [CntBits-1:0] cnt,
                                        input seq_t ack);
    result_t     w;
    int unsigned n;
    int          k;
    run_seq.delete();
    run_resend.delete();
    if (f == FuncStart && !m_active) begin
      m_dup    = 0;
      m_base   = m_next;
      m_unsent = m_base;
      m_end    = (m_base + cnt) & SeqMask;
      m_next   = m_end;
      if (cnt != 0) begin
        m_active = 1'b1;
        emit_window(1'b0);
      end
    end else if (f == FuncAck && m_active) begin
      if (ack == m_base) begin
        m_dup  = 0;
        m_base = (m_base + 1) & SeqMask;
        if (m_phase == PhaseSlow) begin
          m_cwnd = sat_win(m_cwnd + 1);
          emit_window(1'b0);
          if (m_cwnd >= m_ssth) m_phase = PhaseAvoid;
        end else if (m_phase == PhaseAvoid) begin
          m_avoid++;
          if (m_avoid >= m_cwnd) begin
            m_cwnd  = sat_win(m_cwnd + 1);
            m_avoid = 0;
          end
          emit_window(1'b0);
        end else begin
          m_cwnd  = sat_win(m_ssth);
          m_phase = PhaseAvoid;
        end
        if (m_base == m_end) m_active = 1'b0;
      end else if (m_phase == PhaseRecov) begin
        m_cwnd = sat_win(m_cwnd + 1);
        emit_window(1'b0);
      end else begin
        if (m_dup < DupSat) m_dup++;
        if (m_dup == m_dup_thr) begin
          m_ssth = m_cwnd / 2;
          m_cwnd = sat_win(m_ssth + RecovBoost);
          emit_window(1'b1);
          m_phase = PhaseRecov;
          m_dup   = 0;
          m_avoid = 0;
        end
      end
    end else if (f == FuncTimeout && m_active) begin
      m_ssth  = m_cwnd / 2;
      m_cwnd  = 1;
      m_avoid = 0;
      m_dup   = 0;
      emit_window(1'b1);
      m_phase = PhaseSlow;
    end

    n = run_seq.size();
    w = '0;
    w.window    = win_t'(m_cwnd);
    w.threshold = win_t'(m_ssth);
    w.phase     = 2'(m_phase);
    w.done      = !m_active;
    if (n == 0) begin
      w.last = 1'b1;
      exp_words.push_back(w);
    end
    for (k = 0; k < n; k++) begin
      w.send_valid = 1'b1;
      w.seq_no     = run_seq[k];
      w.is_resend  = run_resend[k];
      w.last       = (k == n - 1);
      exp_words.push_back(w);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (want_v !== got_v) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endfunction

  // receiver: free flow, random, sparse and long-block stall modes in turn
  always @(posedge clk_i) begin
    rx_cyc <= rx_cyc + 10'd1;
    if (!rx_stall_en) begin
      pop <= 1'b1;
    end else begin
      case (rx_cyc[9:8])
        2'd0:    pop <= 1'b1;
        2'd1:    pop <= ($urandom_range(0, 1) == 1);
        2'd2:    pop <= (rx_cyc[1:0] == 2'b11);
        default: pop <= (rx_cyc[4] == 1'b0);
      endcase
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (exp_words.size() == 0) begin
        err_count++;
        $display("%0t: result word with none expected, actual seq_no %0h last %0b",
                 $time, seq_no_o, last_o);
      end else begin
        want = exp_words.pop_front();
        check_field("send_valid", 32'(want.send_valid), 32'(send_valid_o));
        check_field("seq_no", 32'(want.seq_no), 32'(seq_no_o));
        check_field("is_resend", 32'(want.is_resend), 32'(is_resend_o));
        check_field("last", 32'(want.last), 32'(last_o));
        check_field("window", 32'(want.window), 32'(window_o));
        check_field("threshold", 32'(want.threshold), 32'(threshold_o));
        check_field("phase", 32'(want.phase), 32'(phase_o));
        check_field("done_res", 32'(want.done), 32'(done_res_o));
      end
    end
  end

  task automatic send_event(input logic [1:0] f, input logic [CntBits-1:0] cnt,
                            input seq_t ack);
    if (tx_gap_en && burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 10);
    end else if (burst_left > 0) begin
      burst_left--;
    end
    push           <= 1'b1;
    func_i         <= f;
    packet_count_i <= cnt;
    ack_no_i       <= ack;
    do @(posedge clk_i); while (full);
    predict_event(f, cnt, ack);
  endtask

  task automatic wait_all_results();
    push <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // writes both registers; only called with no word outstanding
  task automatic cfg_set(input win_t ssth, input logic [1:0] thr);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CfgInitSsthresh;
    cfg_data_i  <= ssth;
    do @(posedge clk_i); while (!cfg_ready_o);
    m_ssth = (ssth > MaxWindow) ? MaxWindow : 32'(ssth);
    cfg_index_i <= CfgDupAckThr;
    cfg_data_i  <= win_t'(thr);
    do @(posedge clk_i); while (!cfg_ready_o);
    m_dup_thr = 32'(thr);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_idle_events();
    send_event(FuncAck, '0, '1);
    send_event(FuncTimeout, '0, '0);
    send_event(FuncUnused, '1, '1);
    send_event(FuncStart, '0, '0);
  endtask

  task automatic test_message_flow();
    send_event(FuncStart, 13'd6, '0);
    send_event(FuncStart, 13'd3, '0);
    send_event(FuncAck, '0, seq_t'(m_base));
    repeat (3) send_event(FuncAck, '0, seq_t'(m_base - 1));
    send_event(FuncAck, '0, seq_t'(m_base + 5));
    send_event(FuncAck, '0, seq_t'(m_base));
    send_event(FuncTimeout, '0, '0);
    while (m_active) send_event(FuncAck, '0, seq_t'(m_base));
  endtask

  task automatic test_random_traffic();
    win_t               ssth_pick [6];
    logic [1:0]         thr_pick  [6];
    int                 p, done_items, roll, dups;
    logic [CntBits-1:0] cnt;
    ssth_pick = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd32, 7'd64};
    thr_pick  = '{2'd3, 2'd1, 2'd0, 2'd2, 2'd1, 2'd3};
    for (p = 0; p < 6; p++) begin
      wait_all_results();
      if (p == 5) cfg_set(win_t'($urandom_range(0, 127)), 2'($urandom_range(0, 3)));
      else cfg_set(ssth_pick[p], thr_pick[p]);
      done_items = 0;
      while (done_items < 50) begin
        roll = $urandom_range(0, 99);
        if (!m_active) begin
          if (roll < 85) begin
            roll = $urandom_range(0, 99);
            if (roll < 5) cnt = '0;
            else if (roll < 75) cnt = CntBits'($urandom_range(1, 24));
            else cnt = CntBits'($urandom_range(25, 200));
            send_event(FuncStart, cnt, seq_t'($urandom));
            done_items++;
          end else begin
            // nothing in flight: acks, timeouts and unknown codes are dropped
            send_event(2'($urandom_range(1, 3)), CntBits'($urandom), seq_t'($urandom));
          end
        end else if (roll < 60) begin
          send_event(FuncAck, CntBits'($urandom), seq_t'(m_base));
          done_items++;
        end else if (roll < 80) begin
          dups = $urandom_range(1, 4);
          repeat (dups) begin
            send_event(FuncAck, CntBits'($urandom),
                       ($urandom_range(0, 1) == 1) ? seq_t'(m_base - 1) : seq_t'($urandom));
            done_items++;
          end
        end else if (roll < 88) begin
          send_event(FuncTimeout, CntBits'($urandom), seq_t'($urandom));
          done_items++;
        end else if (roll < 91) begin
          wait_all_results();
        end else begin
          send_event(($urandom_range(0, 1) == 1) ? FuncStart : FuncUnused,
                     CntBits'($urandom), seq_t'($urandom));
        end
      end
    end
  endtask

  // back-to-back words on both sides with no stalls
  task automatic test_full_rate();
    int k;
    wait_all_results();
    rx_stall_en <= 1'b0;
    tx_gap_en = 1'b0;
    for (k = 0; k < 24; k++) begin
      if (!m_active) send_event(FuncStart, 13'd40, '0);
      else send_event(FuncAck, '0, seq_t'(m_base));
    end
    wait_all_results();
    rx_stall_en <= 1'b1;
    tx_gap_en = 1'b1;
  endtask

  initial begin
    m_phase   = PhaseSlow;
    m_cwnd    = 1;
    m_ssth    = MaxWindow;
    m_avoid   = 0;
    m_dup     = 0;
    m_dup_thr = 3;
    m_base    = 1;
    m_next    = 1;
    m_end     = 1;
    m_unsent  = 1;
    m_active  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_events();
    test_message_flow();
    test_random_traffic();
    test_full_rate();
    wait_all_results();
    repeat (16) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
`default_nettype wire

@@ sim.f @@
design/rcw_pkg.sv
design/rcw_front.sv
design/rcw_jobq.sv
design/rcw_back.sv
design/reno_congestion_window_sender_unit.sv
sim/reno_congestion_window_sender_unit_tb.sv
